@@ sv/apu_pkg.sv @@
// apu_pkg: types and constants shared by the adam parameter update unit
// no dependencies
package apu_pkg;

    localparam int unsigned MUL_W = 33;
    localparam int unsigned PROD_W = 66;
    localparam int unsigned DS_W = 80;
    localparam int unsigned DEN_W = 41;
    localparam int unsigned ITER_W = 7;

    localparam logic [24:0] ONE_Q24 = 25'h100_0000;
    localparam logic [23:0] HALF_Q24 = 24'h80_0000;
    localparam logic [47:0] V_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [40:0] STEP_CAP = 41'h100_0000_0000;

    localparam logic [23:0] LR_RESET = 24'd167772;
    localparam logic [23:0] B1_RESET = 24'd15099494;
    localparam logic [23:0] B2_RESET = 24'd16760439;
    localparam logic [23:0] EPS_RESET = 24'd168;

    localparam logic [1:0] CFG_LR = 2'd0;
    localparam logic [1:0] CFG_B1 = 2'd1;
    localparam logic [1:0] CFG_B2 = 2'd2;
    localparam logic [1:0] CFG_EPS = 2'd3;

    localparam logic ACT_CLEAR = 1'b1;

    typedef enum logic [4:0] {
        S_IDLE,
        S_SWEEP,
        S_SLOT,
        S_RD,
        S_PW1,
        S_PW2,
        S_M1,
        S_M2,
        S_GSQ,
        S_V1,
        S_V2,
        S_V3,
        S_V4,
        S_DIVM,
        S_DIVV,
        S_SQRT,
        S_MS0,
        S_MS1,
        S_MS2,
        S_DIVS
    } t_state;

    typedef struct packed {
        logic              start;
        logic              sqrt;
        logic [ITER_W-1:0] iters;
    } t_ds_req;

endpackage

@@ sv/adam_parameter_update.sv @@
// adam_parameter_update: adam optimizer step with bias correction, one parameter per transaction
// an update folds the index into the store depth, then runs 11 multiply steps on the shared
// multiplier and bit-serial divides of 56, 72 and 80 digits and a 32-digit square root; the
// 80-digit divide comes last, after the final multiply steps. a clear zeroes one moment slot
// per cycle across all NUM_PARAMS slots. start is taken only in idle; busy stays high until
// done; results strobe 1 cycle. after reset the same clearing pass runs before start is taken.
module adam_parameter_update #(
    parameter int NUM_PARAMS = 64,
    parameter int FRAC_BITS  = 24
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_action,
    input  logic [5:0]         i_param_index,
    input  logic signed [31:0] i_param_value,
    input  logic signed [31:0] i_gradient,
    input  logic               i_step_start,
    output logic               o_valid,
    output logic [5:0]         o_result_index,
    output logic signed [31:0] o_new_value,
    output logic               o_saturated,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [23:0]        i_cfg_data
);
    import apu_pkg::*;

    localparam int AW = (NUM_PARAMS > 1) ? $clog2(NUM_PARAMS) : 1;
    localparam int GSQ_SH = 2 * FRAC_BITS - 32;
    localparam logic [PROD_W-1:0] GSQ_RND = (PROD_W'(1) << GSQ_SH) >> 1;

    t_state r_state, n_state;

    logic [23:0] r_lr, r_b1, r_b2, r_eps;
    logic [24:0] r_p1, r_p2;
    logic [AW-1:0] r_cnt;
    logic r_emit, r_step, r_big;
    logic [5:0] r_idx, r_slot;
    logic signed [31:0] r_value, r_grad, r_m;
    logic [79:0] r_mem [NUM_PARAMS];
    logic [79:0] r_rdata;
    logic signed [PROD_W-1:0] r_acc;
    logic [47:0] r_gsq, r_v;
    logic [55:0] r_mhat;
    logic [DEN_W-1:0] r_den;
    logic r_valid, r_sat;
    logic [5:0] r_oidx;
    logic signed [31:0] r_onv;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PROD_W-1:0] prod;
    t_ds_req ds_req;
    logic [DS_W-1:0] ds_num, ds_quo;
    logic [DEN_W-1:0] ds_den;
    logic ds_done;

    logic mem_we;
    logic [AW-1:0] mem_addr;
    logic [79:0] mem_wdata;

    logic signed [MUL_W-1:0] g_ext, ag;
    logic [24:0] c1b, c2b, c1, c2;
    logic [31:0] am;
    logic signed [PROD_W-1:0] p_rnd, m_sum, gsq_full, v_sum;
    logic [47:0] v_cap;
    logic [63:0] vhat;
    logic [39:0] root;
    logic [DEN_W-1:0] den_sum;
    logic [DS_W-1:0] step_num;
    logic [40:0] step;
    logic signed [41:0] nv;

    apu_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    apu_divsqrt u_ds (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (ds_req),
        .i_num   (ds_num),
        .i_den   (ds_den),
        .o_done  (ds_done),
        .o_quo   (ds_quo)
    );

    // datapath helpers
    always_comb begin
        g_ext    = {r_grad[31], r_grad};
        ag       = g_ext[MUL_W-1] ? -g_ext : g_ext;
        c1b      = ONE_Q24 - {1'b0, r_b1};
        c2b      = ONE_Q24 - {1'b0, r_b2};
        c1       = (r_p1 == ONE_Q24) ? ONE_Q24 : ONE_Q24 - r_p1;
        c2       = (r_p2 == ONE_Q24) ? ONE_Q24 : ONE_Q24 - r_p2;
        am       = r_m[31] ? 32'(-{r_m[31], r_m}) : 32'(r_m);
        p_rnd    = (prod + PROD_W'(HALF_Q24)) >>> 24;
        m_sum    = r_acc + prod + PROD_W'(HALF_Q24);
        gsq_full = (prod + GSQ_RND) >>> GSQ_SH;
        v_sum    = r_acc + prod;
        v_cap    = (v_sum > PROD_W'(V_MAX)) ? V_MAX : v_sum[47:0];
        vhat     = (ds_quo[79:64] != '0) ? {64{1'b1}} : ds_quo[63:0];
        root     = r_big ? {ds_quo[31:0], 8'b0} : {8'b0, ds_quo[31:0]};
        den_sum  = DEN_W'(root) + DEN_W'(r_eps);
        step_num = (DS_W'(prod) << 24) + DS_W'(r_acc);
        step     = (ds_quo > DS_W'(STEP_CAP)) ? STEP_CAP : ds_quo[40:0];
        nv       = r_m[31] ? {{10{r_value[31]}}, r_value} + {1'b0, step}
                           : {{10{r_value[31]}}, r_value} - {1'b0, step};
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) n_state = (i_action == ACT_CLEAR) ? S_SWEEP : S_SLOT;
            end
            S_SWEEP: if (r_cnt == AW'(NUM_PARAMS - 1)) n_state = S_IDLE;
            S_SLOT:  if (int'(r_slot) < NUM_PARAMS) n_state = S_RD;
            S_RD:    n_state = S_PW1;
            S_PW1:   n_state = S_PW2;
            S_PW2:   n_state = S_M1;
            S_M1:    n_state = S_M2;
            S_M2:    n_state = S_GSQ;
            S_GSQ:   n_state = S_V1;
            S_V1:    n_state = S_V2;
            S_V2:    n_state = S_V3;
            S_V3:    n_state = S_V4;
            S_V4:    n_state = S_DIVM;
            S_DIVM:  if (ds_done) n_state = S_DIVV;
            S_DIVV:  if (ds_done) n_state = S_SQRT;
            S_SQRT:  if (ds_done) n_state = S_MS0;
            S_MS0:   n_state = S_MS1;
            S_MS1:   n_state = S_MS2;
            S_MS2:   n_state = S_DIVS;
            S_DIVS:  if (ds_done) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // unit controls
    always_comb begin
        mul_a     = '0;
        mul_b     = '0;
        ds_req    = '0;
        ds_num    = '0;
        ds_den    = '0;
        mem_we    = 1'b0;
        mem_addr  = AW'(r_slot);
        mem_wdata = '0;
        busy      = (r_state != S_IDLE);
        case (r_state)
            S_SWEEP: begin
                mem_we   = 1'b1;
                mem_addr = r_cnt;
            end
            S_RD: begin
                mul_a = MUL_W'(r_p1);
                mul_b = MUL_W'(r_b1);
            end
            S_PW1: begin
                mul_a = MUL_W'(r_p2);
                mul_b = MUL_W'(r_b2);
            end
            S_PW2: begin
                mul_a = {r_rdata[79], r_rdata[79:48]};
                mul_b = MUL_W'(r_b1);
            end
            S_M1: begin
                mul_a = g_ext;
                mul_b = MUL_W'(c1b);
            end
            S_M2: begin
                mul_a = ag;
                mul_b = ag;
            end
            S_GSQ: begin
                mul_a = MUL_W'(r_rdata[23:0]);
                mul_b = MUL_W'(r_b2);
            end
            S_V1: begin
                mul_a = MUL_W'(r_gsq[23:0]);
                mul_b = MUL_W'(c2b);
            end
            S_V2: begin
                mul_a = MUL_W'(r_rdata[47:24]);
                mul_b = MUL_W'(r_b2);
            end
            S_V3: begin
                mul_a = MUL_W'(r_gsq[47:24]);
                mul_b = MUL_W'(c2b);
            end
            S_V4: begin
                mem_we       = 1'b1;
                mem_wdata    = {r_m, v_cap};
                ds_req.start = 1'b1;
                ds_req.iters = ITER_W'(56);
                ds_num       = {am, 48'b0};
                ds_den       = DEN_W'(c1);
            end
            S_DIVM: begin
                if (ds_done) begin
                    ds_req.start = 1'b1;
                    ds_req.iters = ITER_W'(72);
                    ds_num       = {r_v, 32'b0};
                    ds_den       = DEN_W'(c2);
                end
            end
            S_DIVV: begin
                if (ds_done) begin
                    ds_req.start = 1'b1;
                    ds_req.sqrt  = 1'b1;
                    ds_req.iters = ITER_W'(32);
                    ds_num       = (vhat[63:48] != '0) ? {vhat, 16'b0} : {vhat[47:0], 32'b0};
                end
            end
            S_MS0: begin
                mul_a = MUL_W'(r_mhat[23:0]);
                mul_b = MUL_W'(r_lr);
            end
            S_MS1: begin
                mul_a = MUL_W'(r_mhat[55:24]);
                mul_b = MUL_W'(r_lr);
            end
            S_MS2: begin
                ds_req.start = 1'b1;
                ds_req.iters = ITER_W'(80);
                ds_num       = step_num;
                ds_den       = r_den;
            end
            default: ;
        endcase
    end

    // moment store, m in the upper 32 bits and v in the lower 48
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_addr] <= mem_wdata;
        r_rdata <= r_mem[mem_addr];
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_SWEEP;
            r_cnt   <= '0;
            r_emit  <= 1'b0;
            r_valid <= 1'b0;
            r_lr    <= LR_RESET;
            r_b1    <= B1_RESET;
            r_b2    <= B2_RESET;
            r_eps   <= EPS_RESET;
            r_p1    <= ONE_Q24;
            r_p2    <= ONE_Q24;
        end else begin
            r_state <= n_state;
            r_valid <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_LR:  r_lr  <= i_cfg_data;
                    CFG_B1:  r_b1  <= i_cfg_data;
                    CFG_B2:  r_b2  <= i_cfg_data;
                    CFG_EPS: r_eps <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (start && i_action == ACT_CLEAR) begin
                        r_cnt  <= '0;
                        r_emit <= 1'b1;
                        r_p1   <= ONE_Q24;
                        r_p2   <= ONE_Q24;
                    end
                end
                S_SWEEP: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == AW'(NUM_PARAMS - 1)) begin
                        r_valid <= r_emit;
                        r_emit  <= 1'b0;
                    end
                end
                S_PW1: if (r_step) r_p1 <= p_rnd[24:0];
                S_PW2: if (r_step) r_p2 <= p_rnd[24:0];
                S_DIVS: if (ds_done) r_valid <= 1'b1;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_idx   <= i_param_index;
                    r_slot  <= i_param_index;
                    r_value <= i_param_value;
                    r_grad  <= i_gradient;
                    r_step  <= i_step_start;
                end
            end
            S_SWEEP: begin
                r_oidx <= r_idx;
                r_onv  <= '0;
                r_sat  <= 1'b0;
            end
            // fold index into the store depth
            S_SLOT: if (int'(r_slot) >= NUM_PARAMS) r_slot <= 6'(int'(r_slot) - NUM_PARAMS);
            S_M1:   r_acc <= prod;
            S_M2:   r_m <= m_sum[55:24];
            S_GSQ:  r_gsq <= (gsq_full > PROD_W'(V_MAX)) ? V_MAX : gsq_full[47:0];
            S_V1:   r_acc <= prod;
            // low halves carry into the high half with rounding
            S_V2:   r_acc <= (r_acc + prod + PROD_W'(HALF_Q24)) >>> 24;
            S_V3:   r_acc <= r_acc + prod;
            S_V4:   r_v <= v_cap;
            S_DIVM: if (ds_done) r_mhat <= ds_quo[55:0];
            S_DIVV: if (ds_done) r_big <= (vhat[63:48] != '0);
            S_SQRT: if (ds_done) r_den <= (den_sum == '0) ? DEN_W'(1) : den_sum;
            S_MS1:  r_acc <= prod;
            S_DIVS: begin
                if (ds_done) begin
                    r_oidx <= r_idx;
                    if (nv > 42'sd2147483647) begin
                        r_onv <= 32'h7FFF_FFFF;
                        r_sat <= 1'b1;
                    end else if (nv < -42'sd2147483648) begin
                        r_onv <= 32'h8000_0000;
                        r_sat <= 1'b1;
                    end else begin
                        r_onv <= nv[31:0];
                        r_sat <= 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_valid        = r_valid;
    assign o_result_index = r_oidx;
    assign o_new_value    = r_onv;
    assign o_saturated    = r_sat;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state) == S_DIVS || $past(r_state) == S_SWEEP)
        else $error("result strobe outside final step");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIVS |-> r_den != '0)
        else $error("zero divisor in step divide");

endmodule

@@ sv/apu_mul.sv @@
// apu_mul: shared signed 33x33 multiplier with registered product
// depends on apu_pkg
module apu_mul (
    input  logic                                i_clk,
    input  logic signed [apu_pkg::MUL_W-1:0]    i_a,
    input  logic signed [apu_pkg::MUL_W-1:0]    i_b,
    output logic signed [apu_pkg::PROD_W-1:0]   o_prod
);
    import apu_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
    end

    assign o_prod = r_prod;

endmodule

@@ sv/apu_divsqrt.sv @@
// apu_divsqrt: bit-serial restoring divider and square root, one digit per cycle
// depends on apu_pkg; operands arrive left aligned in the 80-bit numerator
module apu_divsqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  apu_pkg::t_ds_req            i_req,
    input  logic [apu_pkg::DS_W-1:0]    i_num,
    input  logic [apu_pkg::DEN_W-1:0]   i_den,
    output logic                        o_done,
    output logic [apu_pkg::DS_W-1:0]    o_quo
);
    import apu_pkg::*;

    logic              r_run, r_done, r_sqrt;
    logic [ITER_W-1:0] r_cnt;
    logic [DS_W-1:0]   r_num, r_quo;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W:0]    r_rem;

    logic [DEN_W:0] shifted, trial, n_rem;
    logic           ge;

    always_comb begin
        if (r_sqrt) begin
            shifted = {r_rem[DEN_W-2:0], r_num[DS_W-1:DS_W-2]};
            trial   = {8'b0, r_quo[31:0], 2'b01};
        end else begin
            shifted = {r_rem[DEN_W-1:0], r_num[DS_W-1]};
            trial   = {1'b0, r_den};
        end
        ge    = shifted >= trial;
        n_rem = ge ? shifted - trial : shifted;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_run <= 1'b1;
                r_cnt <= i_req.iters;
            end else if (r_run) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ITER_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_sqrt <= i_req.sqrt;
            r_num  <= i_num;
            r_den  <= i_den;
            r_rem  <= '0;
            r_quo  <= '0;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DS_W-2:0], ge};
            r_num <= r_sqrt ? {r_num[DS_W-3:0], 2'b00} : {r_num[DS_W-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule
